// ===== rtl/mcw_pkg.sv =====
// Shared types and codes of the multi-client watchdog.
// Used by mcw_cell, multi_client_watchdog, mcw_checker and the testbench; no dependencies.
`default_nettype none
package mcw_pkg;

  // Port widths of the fixed fields
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 4;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;
  localparam int ID_W        = 3;
  localparam int TMO_W       = 16;
  localparam int STATUS_W    = 4;
  localparam int ACT_W       = 4;

  // Item kinds
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_KICK = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // Result status codes
  localparam logic [3:0] ST_KICKED      = 4'd0;
  localparam logic [3:0] ST_FULL        = 4'd1;
  localparam logic [3:0] ST_DONE        = 4'd2;
  localparam logic [3:0] ST_NOT_FOUND   = 4'd3;
  localparam logic [3:0] ST_TICK_OK     = 4'd4;
  localparam logic [3:0] ST_EXP_REMOVED = 4'd5;
  localparam logic [3:0] ST_FATAL       = 4'd6;
  localparam logic [3:0] ST_EXP_KEPT    = 4'd7;
  localparam logic [3:0] ST_HALTED      = 4'd8;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_MAX_CLIENTS = 2'd0;
  localparam logic [1:0] REG_REMOVE_MASK = 2'd1;
  localparam logic [1:0] REG_FATAL_MASK  = 2'd2;

  // Command broadcast to every cell of the table
  typedef struct packed {
    logic            kick_go;    // shift in from the left up to the matching cell
    logic            done_go;    // shift in from the right from the matching cell on
    logic            drop_tail;  // invalidate the oldest entry
    logic [ID_W-1:0] cmp_id;
  } cell_cmd_t;

  // One result beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     expired_id;
    logic [ACT_W-1:0]    active_count;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/mcw_cell.sv =====
// One slot of the recency-ordered watchdog table: valid, id and deadline.
// Depends on mcw_pkg; instantiated in a row by multi_client_watchdog.
`default_nettype none
module mcw_cell #(
  parameter int TW = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mcw_pkg::cell_cmd_t    cmd,
  // left neighbor (newer entry, or the new entry for the front cell)
  input  logic                  left_valid,
  input  logic [mcw_pkg::ID_W-1:0] left_id,
  input  logic [TW-1:0]         left_dl,
  // right neighbor (older entry)
  input  logic                  right_valid,
  input  logic [mcw_pkg::ID_W-1:0] right_id,
  input  logic [TW-1:0]         right_dl,
  // own contents
  output logic                  own_valid,
  output logic [mcw_pkg::ID_W-1:0] own_id,
  output logic [TW-1:0]         own_dl,
  // match chain, left to right
  input  logic                  match_in,
  output logic                  match_out,
  // oldest-entry chain, right to left
  input  logic                  tail_in_valid,
  input  logic [mcw_pkg::ID_W-1:0] tail_in_id,
  input  logic [TW-1:0]         tail_in_dl,
  output logic                  tail_out_valid,
  output logic [mcw_pkg::ID_W-1:0] tail_out_id,
  output logic [TW-1:0]         tail_out_dl
);
  import mcw_pkg::*;

  logic            valid_r, valid_nxt;
  logic [ID_W-1:0] id_r, id_nxt;
  logic [TW-1:0]   dl_r, dl_nxt;
  logic            hit;
  logic            is_tail;

  assign hit       = valid_r && (id_r == cmd.cmp_id);
  assign match_out = match_in | hit;
  assign is_tail   = valid_r && !right_valid;

  assign own_valid = valid_r;
  assign own_id    = id_r;
  assign own_dl    = dl_r;

  // pass the oldest entry toward the front
  assign tail_out_valid = is_tail ? 1'b1 : tail_in_valid;
  assign tail_out_id    = is_tail ? id_r : tail_in_id;
  assign tail_out_dl    = is_tail ? dl_r : tail_in_dl;

  always_comb begin
    valid_nxt = valid_r;
    id_nxt    = id_r;
    dl_nxt    = dl_r;
    if (cmd.kick_go && !match_in) begin
      valid_nxt = left_valid;
      id_nxt    = left_id;
      dl_nxt    = left_dl;
    end else if (cmd.done_go && match_out) begin
      valid_nxt = right_valid;
      id_nxt    = right_id;
      dl_nxt    = right_dl;
    end else if (cmd.drop_tail && is_tail) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
    dl_r <= dl_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/multi_client_watchdog.sv =====
// Top level of the multi-client watchdog: row of mcw_cell slots, control,
// configuration registers and a two-beat result buffer. Depends on mcw_pkg.
//
//   channel | dir | handshake             | payload
//   in_     | in  | in_tvalid/in_tready   | tuser kind, tdata id+timeout
//   out_    | out | out_tvalid/out_tready | tuser status, tdata id+count
//   cfg_    | in  | APB, pready tied high | max_clients, remove/fatal masks
//
// Each item is resolved in the cycle it is accepted: the id compare, the
// match chain and the oldest-entry chain through the cell row, then one
// wrap-aware subtract, set that cycle's depth. One item per cycle while the result buffer has room.
// Results wait in a two-beat buffer; the input stalls only when it is full.
// Reset is synchronous; no clearing pass.
`default_nettype none
module multi_client_watchdog #(
  parameter int MAX_ENTRIES = 8,
  parameter int NUM_IDS     = 8,
  parameter int TIME_BITS   = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [mcw_pkg::IN_TDATA_W-1:0] in_tdata,   // [2:0] client_id, [18:3] timeout_ticks
  input  logic [mcw_pkg::IN_TUSER_W-1:0] in_tuser,   // [1:0] kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [mcw_pkg::OUT_TDATA_W-1:0] out_tdata, // [2:0] expired_id, [6:3] active_count
  output logic [mcw_pkg::OUT_TUSER_W-1:0] out_tuser, // [3:0] status
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [mcw_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [mcw_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [mcw_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import mcw_pkg::*;

  localparam int TW  = TIME_BITS;
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int CMW = (CW > 4) ? CW : 4;

  // configuration
  logic [3:0] max_clients_r;
  logic [7:0] remove_mask_r;
  logic [7:0] fatal_mask_r;
  logic       cfg_wr;

  // control state
  logic [TW-1:0] time_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          halted_r;

  // item fields
  logic [1:0]       kind;
  logic [ID_W-1:0]  cid;
  logic [TMO_W-1:0] tmo;
  logic             push, pop;
  logic             id_ok;

  // cell row wiring
  cell_cmd_t       cmd;
  logic            v_a   [0:MAX_ENTRIES];
  logic [ID_W-1:0] id_a  [0:MAX_ENTRIES];
  logic [TW-1:0]   dl_a  [0:MAX_ENTRIES];
  logic            m_c   [0:MAX_ENTRIES];
  logic            tv_c  [0:MAX_ENTRIES];
  logic [ID_W-1:0] tid_c [0:MAX_ENTRIES];
  logic [TW-1:0]   tdl_c [0:MAX_ENTRIES];

  logic            found;
  logic            full;
  logic [TW-1:0]   time_inc;
  logic [TW-1:0]   diff;
  logic            expired;
  logic [TW-1:0]   new_dl;

  logic            kick_go, done_go, drop_tail, tick_go, fatal_go, grow;
  logic [3:0]      st;
  logic [ID_W-1:0] xid;
  logic [CMW-1:0]  count_ext, max_ext;

  // result buffer
  result_t res_q [0:1];
  logic    wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  result_t res_in;

  assign kind = in_tuser;
  assign cid  = in_tdata[ID_W-1:0];
  assign tmo  = in_tdata[ID_W +: TMO_W];

  assign in_tready  = (fill_r != 2'd2);
  assign out_tvalid = (fill_r != 2'd0);
  assign push       = in_tvalid && in_tready;
  assign pop        = out_tvalid && out_tready;

  assign id_ok = (int'(cid) < NUM_IDS);

  // ---------------- cell row ----------------
  assign v_a[MAX_ENTRIES]   = 1'b0;
  assign id_a[MAX_ENTRIES]  = '0;
  assign dl_a[MAX_ENTRIES]  = '0;
  assign m_c[0]             = 1'b0;
  assign tv_c[MAX_ENTRIES]  = 1'b0;
  assign tid_c[MAX_ENTRIES] = '0;
  assign tdl_c[MAX_ENTRIES] = '0;

  assign new_dl = time_r + TW'(tmo);

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic            lv;
    logic [ID_W-1:0] lid;
    logic [TW-1:0]   ldl;
    logic            ov;
    logic [ID_W-1:0] oid;
    logic [TW-1:0]   odl;

    if (i == 0) begin : g_front
      assign lv  = 1'b1;
      assign lid = cid;
      assign ldl = new_dl;
    end else begin : g_mid
      assign lv  = g_cell[i-1].ov;
      assign lid = g_cell[i-1].oid;
      assign ldl = g_cell[i-1].odl;
    end

    assign v_a[i]  = ov;
    assign id_a[i] = oid;
    assign dl_a[i] = odl;

    mcw_cell #(.TW(TW)) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .cmd            (cmd),
      .left_valid     (lv),
      .left_id        (lid),
      .left_dl        (ldl),
      .right_valid    (v_a[i+1]),
      .right_id       (id_a[i+1]),
      .right_dl       (dl_a[i+1]),
      .own_valid      (ov),
      .own_id         (oid),
      .own_dl         (odl),
      .match_in       (m_c[i]),
      .match_out      (m_c[i+1]),
      .tail_in_valid  (tv_c[i+1]),
      .tail_in_id     (tid_c[i+1]),
      .tail_in_dl     (tdl_c[i+1]),
      .tail_out_valid (tv_c[i]),
      .tail_out_id    (tid_c[i]),
      .tail_out_dl    (tdl_c[i])
    );
  end

  assign found = m_c[MAX_ENTRIES];

  // ---------------- control ----------------
  assign count_ext = CMW'(count_r);
  assign max_ext   = CMW'(max_clients_r);
  assign full      = (count_ext >= max_ext) || (count_r >= CW'(MAX_ENTRIES));

  assign time_inc = time_r + TW'(1);
  assign diff     = time_inc - tdl_c[0];
  assign expired  = tv_c[0] && (diff != '0) && !diff[TW-1];

  always_comb begin
    st        = ST_NOT_FOUND;
    xid       = '0;
    kick_go   = 1'b0;
    done_go   = 1'b0;
    drop_tail = 1'b0;
    tick_go   = 1'b0;
    fatal_go  = 1'b0;
    if (halted_r) begin
      st = ST_HALTED;
    end else begin
      unique case (kind)
        KIND_TICK: begin
          tick_go = 1'b1;
          st      = ST_TICK_OK;
          if (expired) begin
            xid = tid_c[0];
            if (remove_mask_r[tid_c[0]]) begin
              drop_tail = 1'b1;
              st        = ST_EXP_REMOVED;
            end else if (fatal_mask_r[tid_c[0]]) begin
              fatal_go = 1'b1;
              st       = ST_FATAL;
            end else begin
              st = ST_EXP_KEPT;
            end
          end
        end
        KIND_KICK: begin
          if (id_ok) begin
            if (found || !full) begin
              kick_go = 1'b1;
              st      = ST_KICKED;
            end else begin
              st = ST_FULL;
            end
          end
        end
        KIND_DONE: begin
          if (id_ok && found) begin
            done_go = 1'b1;
            st      = ST_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  assign cmd.kick_go   = push && kick_go;
  assign cmd.done_go   = push && done_go;
  assign cmd.drop_tail = push && drop_tail;
  assign cmd.cmp_id    = cid;

  assign grow = kick_go && !found;

  always_comb begin
    count_nxt = count_r;
    if (grow) begin
      count_nxt = count_r + CW'(1);
    end else if (done_go || drop_tail) begin
      count_nxt = count_r - CW'(1);
    end
  end

  assign res_in.status       = st;
  assign res_in.expired_id   = xid;
  assign res_in.active_count = 4'(CMW'(count_nxt));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r   <= '0;
      count_r  <= '0;
      halted_r <= 1'b0;
    end else if (push) begin
      count_r <= count_nxt;
      if (tick_go) begin
        time_r <= time_inc;
      end
      if (fatal_go) begin
        halted_r <= 1'b1;
      end
    end
  end

  // ---------------- result buffer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      res_q[wr_ptr_r] <= res_in;
    end
  end

  assign out_tuser = res_q[rd_ptr_r].status;
  assign out_tdata = {1'b0, res_q[rd_ptr_r].active_count, res_q[rd_ptr_r].expired_id};

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_clients_r <= 4'd8;
      remove_mask_r <= 8'd0;
      fatal_mask_r  <= 8'd0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_MAX_CLIENTS: max_clients_r <= cfg_pwdata[3:0];
        REG_REMOVE_MASK: remove_mask_r <= cfg_pwdata[7:0];
        REG_FATAL_MASK:  fatal_mask_r  <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_MAX_CLIENTS: cfg_prdata = CFG_DATA_W'(max_clients_r);
      REG_REMOVE_MASK: cfg_prdata = CFG_DATA_W'(remove_mask_r);
      REG_FATAL_MASK:  cfg_prdata = CFG_DATA_W'(fatal_mask_r);
      default:         cfg_prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/mcw_checker.sv =====
// Port-level assertions for multi_client_watchdog, bound to the top level.
// Depends on mcw_pkg and the top level's port names.
`default_nettype none
module mcw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mcw_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [mcw_pkg::OUT_TUSER_W-1:0] out_tuser
);
  import mcw_pkg::*;

  logic seen_fatal_r;

  // remember that a fatal beat has been delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_fatal_r <= 1'b0;
    end else if (out_tvalid && out_tready && (out_tuser == ST_FATAL)) begin
      seen_fatal_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_stall_only_when_buffered: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result waiting");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_halted_after_fatal: assert property (@(posedge clk) disable iff (!rst_n)
    seen_fatal_r && out_tvalid |-> out_tuser == ST_HALTED)
    else $error("result after fatal beat is not halted");

endmodule

bind multi_client_watchdog mcw_checker u_mcw_checker (.*);
`default_nettype wire

// ===== tb/sv/mcw_tb_pkg.sv =====
// Client-table tracker for the multi-client watchdog testbench: predicts the
// result beat of every accepted input beat and checks the returned beats.
// Depends on mcw_pkg for the item kinds, status codes and result layout.
package mcw_tb_pkg;
  import mcw_pkg::*;

  localparam int TABLE_DEPTH = 8;
  localparam int STATUS_CODES = 9;

  class wd_table_tracker;
    logic [ID_W-1:0] slot_id [TABLE_DEPTH];
    logic [31:0]     slot_deadline [TABLE_DEPTH];
    int              live_count;
    logic [31:0]     now_ticks;
    bit              halted;
    logic [3:0]      max_clients;
    logic [7:0]      remove_mask;
    logic [7:0]      fatal_mask;
    result_t         awaited_results [$];
    int              items_seen;
    int              results_seen;
    int              mismatches;
    int              status_hits [STATUS_CODES];

    function new();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot_id[i] = '0;
        slot_deadline[i] = '0;
      end
      for (int i = 0; i < STATUS_CODES; i++) status_hits[i] = 0;
      live_count   = 0;
      now_ticks    = '0;
      halted       = 1'b0;
      max_clients  = 4'd8;
      remove_mask  = '0;
      fatal_mask   = '0;
      items_seen   = 0;
      results_seen = 0;
      mismatches   = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [7:0] value);
      case (idx)
        REG_MAX_CLIENTS: max_clients = value[3:0];
        REG_REMOVE_MASK: remove_mask = value;
        REG_FATAL_MASK:  fatal_mask = value;
        default: ;
      endcase
    endfunction

    function int find_client(logic [ID_W-1:0] id);
      for (int i = 0; i < live_count; i++)
        if (slot_id[i] == id) return i;
      return -1;
    endfunction

    // Close the gap left by the dropped entry; order of the rest is kept.
    function void drop_slot(int pos);
      for (int i = pos; i + 1 < live_count; i++) begin
        slot_id[i] = slot_id[i + 1];
        slot_deadline[i] = slot_deadline[i + 1];
      end
      live_count--;
      slot_id[live_count] = '0;
      slot_deadline[live_count] = '0;
    endfunction

    function void push_front(logic [ID_W-1:0] id, logic [31:0] deadline);
      for (int i = live_count; i > 0; i--) begin
        slot_id[i] = slot_id[i - 1];
        slot_deadline[i] = slot_deadline[i - 1];
      end
      slot_id[0] = id;
      slot_deadline[0] = deadline;
      live_count++;
    endfunction

    function void note_item(logic [1:0] kind, logic [ID_W-1:0] id, logic [TMO_W-1:0] tmo);
      result_t     want;
      int          pos;
      int          limit;
      int          tail;
      logic [31:0] lag;
      want.status = ST_NOT_FOUND;
      want.expired_id = '0;
      limit = (max_clients < TABLE_DEPTH) ? max_clients : TABLE_DEPTH;
      if (halted) begin
        want.status = ST_HALTED;
      end else begin
        case (kind)
          KIND_TICK: begin
            now_ticks = now_ticks + 32'd1;
            want.status = ST_TICK_OK;
            if (live_count > 0) begin
              tail = live_count - 1;
              // wrap-aware: expired when the lag is nonzero and not negative
              lag = now_ticks - slot_deadline[tail];
              if (lag != 0 && !lag[31]) begin
                want.expired_id = slot_id[tail];
                if (remove_mask[slot_id[tail]]) begin
                  drop_slot(tail);
                  want.status = ST_EXP_REMOVED;
                end else if (fatal_mask[slot_id[tail]]) begin
                  halted = 1'b1;
                  want.status = ST_FATAL;
                end else begin
                  want.status = ST_EXP_KEPT;
                end
              end
            end
          end
          KIND_KICK: begin
            pos = find_client(id);
            if (pos >= 0) begin
              drop_slot(pos);
              push_front(id, now_ticks + {16'd0, tmo});
              want.status = ST_KICKED;
            end else if (live_count >= limit) begin
              want.status = ST_FULL;
            end else begin
              push_front(id, now_ticks + {16'd0, tmo});
              want.status = ST_KICKED;
            end
          end
          KIND_DONE: begin
            pos = find_client(id);
            if (pos >= 0) begin
              drop_slot(pos);
              want.status = ST_DONE;
            end
          end
          default: ;
        endcase
      end
      want.active_count = live_count[ACT_W-1:0];
      items_seen++;
      awaited_results.push_back(want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      results_seen++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status %0d expired_id %0d active_count %0d",
                   got.status, got.expired_id, got.active_count);
        return;
      end
      want = awaited_results.pop_front();
      status_hits[want.status]++;
      if (got.status !== want.status || got.expired_id !== want.expired_id ||
          got.active_count !== want.active_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at result %0d: status exp %0d got %0d, expired_id exp %0d got %0d, active_count exp %0d got %0d",
                   results_seen, want.status, got.status, want.expired_id,
                   got.expired_id, want.active_count, got.active_count);
      end
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_top.sv =====
// Top of the multi-client watchdog testbench: clock, reset, stream and APB
// drivers, result monitor and run control. Depends on mcw_pkg, mcw_tb_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mcw_pkg::*;
  import mcw_tb_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_SPARSE, STALL_BLOCK} stall_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [2:0] client_id, [18:3] timeout_ticks
  logic [IN_TUSER_W-1:0]  in_tuser = '0;   // [1:0] kind
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [2:0] expired_id, [6:3] active_count
  logic [OUT_TUSER_W-1:0] out_tuser;       // [3:0] status
  logic                   cfg_psel = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr = '0;
  logic [CFG_DATA_W-1:0]  cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  wd_table_tracker tracker;
  int          cycle_count = 0;
  int          burst_left = 0;
  int          reg_writes = 0;
  int          stall_tick = 0;
  stall_mode_t stall_mode = STALL_NONE;

  multi_client_watchdog u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Both channels are sampled in one process, so a beat is always noted
  // before any result it could cause is checked.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        tracker.note_item(in_tuser, in_tdata[2:0], in_tdata[18:3]);
      if (out_tvalid && out_tready)
        tracker.check_result({out_tuser[3:0], out_tdata[2:0], out_tdata[6:3]});
    end
  end

  // Receiver back-pressure from a randomly switched stall pattern.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 64 == 0) stall_mode <= stall_mode_t'($urandom_range(0, 3));
    case (stall_mode)
      STALL_NONE:   out_tready <= 1'b1;
      STALL_RANDOM: out_tready <= ($urandom_range(0, 9) < 7);
      STALL_SPARSE: out_tready <= (stall_tick % 4 == 0);
      default:      out_tready <= ((stall_tick % 64) < 40);
    endcase
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, tracker.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Present one beat and hold it until it is taken.
  task automatic send_item(input logic [1:0] kind, input logic [ID_W-1:0] id,
                           input logic [TMO_W-1:0] tmo);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {5'd0, tmo, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Bursts of random length, separated by random gaps.
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender until every awaited result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.pending() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value,
                           input logic [31:0] fill);
    logic [31:0] keep;
    keep = (idx == REG_MAX_CLIENTS) ? 32'h0000_000F : 32'h0000_00FF;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= (fill & ~keep) | ({24'd0, value} & keep);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    tracker.set_register(idx, value & keep[7:0]);
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic configure(input logic [3:0] max_clients, input logic [7:0] remove_mask,
                           input logic [7:0] fatal_mask, input logic [31:0] fill);
    drain();
    write_reg(REG_MAX_CLIENTS, {4'd0, max_clients}, fill);
    write_reg(REG_REMOVE_MASK, remove_mask, fill);
    write_reg(REG_FATAL_MASK, fatal_mask, fill);
  endtask

  // Mostly ticks and kicks with short timeouts so entries expire often.
  task automatic send_random(output bit counted);
    int              pick;
    logic [1:0]      kind;
    logic [ID_W-1:0] id;
    logic [TMO_W-1:0] tmo;
    pick = $urandom_range(0, 99);
    if (pick < 48)      kind = KIND_TICK;
    else if (pick < 83) kind = KIND_KICK;
    else if (pick < 97) kind = KIND_DONE;
    else                kind = KIND_SPARE;
    id = ID_W'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 80)      tmo = TMO_W'($urandom_range(0, 24));
    else if (pick < 95) tmo = TMO_W'($urandom_range(0, 400));
    else if (pick < 97) tmo = 16'hFFFF;
    else                tmo = TMO_W'($urandom());
    send_item(kind, id, tmo);
    counted = (kind != KIND_SPARE);
  endtask

  task automatic run_phase(input int count, input logic [3:0] max_clients,
                           input logic [7:0] remove_mask, input logic [7:0] fatal_mask);
    int sent;
    bit counted;
    configure(max_clients, remove_mask, fatal_mask, $urandom());
    sent = 0;
    while (sent < count) begin
      send_random(counted);
      if (counted) sent++;
      pace();
      if ($urandom_range(0, 199) == 0) drain();
    end
  endtask

  initial begin
    logic [7:0] mask_a;
    tracker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, not found, repeated expiry while kept, full table,
    // re-kick to front, spare kind, done twice.
    send_item(KIND_TICK, 3'd0, 16'd0);
    send_item(KIND_DONE, 3'd3, 16'd0);
    send_item(KIND_KICK, 3'd0, 16'd0);
    send_item(KIND_TICK, 3'd0, 16'd0);
    send_item(KIND_TICK, 3'd7, 16'hFFFF);
    send_item(KIND_KICK, 3'd7, 16'hFFFF);
    for (int i = 1; i < 7; i++) send_item(KIND_KICK, i[2:0], 16'd5);
    send_item(KIND_KICK, 3'd0, 16'd2);
    send_item(KIND_SPARE, 3'd5, 16'h1234);
    send_item(KIND_DONE, 3'd7, 16'd0);
    send_item(KIND_DONE, 3'd7, 16'd0);
    send_item(KIND_TICK, 3'd0, 16'd0);

    // Limit of one: new clients refused, re-kick allowed; remove beats fatal.
    configure(4'd1, 8'hFF, 8'hFF, 32'd0);
    send_item(KIND_KICK, 3'd7, 16'd3);
    send_item(KIND_KICK, 3'd3, 16'd9);
    repeat (6) send_item(KIND_TICK, 3'd0, 16'd0);

    run_phase(300, 4'd8, 8'h00, 8'h00);
    run_phase(250, 4'd3, 8'h0F, 8'h00);
    run_phase(250, 4'd15, 8'hFF, 8'hFF);
    run_phase(100, 4'd0, 8'h55, 8'h00);
    run_phase(250, 4'd1, 8'hAA, 8'h2A);
    repeat (4) begin
      mask_a = 8'($urandom());
      run_phase(150, 4'($urandom_range(0, 15)), mask_a, mask_a & 8'($urandom()));
    end
    // Fatal ids not covered by the remove mask: halts, then every beat halted.
    run_phase(200, 4'd8, 8'h0F, 8'hF0);

    drain();
    repeat (16) @(posedge clk);
    $display("run covered %0d input beats, %0d result beats, %0d register writes",
             tracker.items_seen, tracker.results_seen, reg_writes);
    $display("status mix: kicked %0d full %0d done %0d not-found %0d tick-ok %0d removed %0d fatal %0d kept %0d halted %0d",
             tracker.status_hits[ST_KICKED], tracker.status_hits[ST_FULL],
             tracker.status_hits[ST_DONE], tracker.status_hits[ST_NOT_FOUND],
             tracker.status_hits[ST_TICK_OK], tracker.status_hits[ST_EXP_REMOVED],
             tracker.status_hits[ST_FATAL], tracker.status_hits[ST_EXP_KEPT],
             tracker.status_hits[ST_HALTED]);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results outstanding", tracker.mismatches,
               tracker.pending());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mcw_pkg.sv
rtl/mcw_cell.sv
rtl/multi_client_watchdog.sv
rtl/mcw_checker.sv
tb/sv/mcw_tb_pkg.sv
tb/sv/tb_top.sv
